/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by haptic_detent_snap
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`endif

/* hw/rtl/hds_pkg.sv */
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types and constants of the haptic detent snap block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hds_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned DetW   = 16;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdW = 2;
  localparam int unsigned DataW  = 80;

  typedef enum logic [CmdW-1:0] {
    CMD_TRACK      = 2'd0,
    CMD_MOVE       = 2'd1,
    CMD_CONTINUOUS = 2'd2,
    CMD_NONE       = 2'd3
  } hds_cmd_e;

  typedef enum logic [CfgIdW-1:0] {
    REG_ORIGIN = 2'd0,
    REG_STEPS  = 2'd1,
    REG_COUNTS = 2'd2,
    REG_UNUSED = 2'd3
  } hds_reg_e;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } hds_div_stat_t;

endpackage

/* hw/rtl/hds_div.sv */
// ----------------------------------------------------------------------------
// hds_div
// Restoring radix-2 divider, 32-bit dividend by nonzero 16-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hds_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [hds_pkg::PosW-1:0]        dividend_i,
  input  logic [hds_pkg::DetW-1:0]        divisor_i,
  output hds_pkg::hds_div_stat_t          stat_o,
  output logic [hds_pkg::PosW-1:0]        quotient_o,
  output logic [hds_pkg::DetW-1:0]        remainder_o
);
  import hds_pkg::*;

  localparam int unsigned CntW = $clog2(PosW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [PosW-1:0]     quot_q, quot_d;
  logic [DetW-1:0]     rem_q, rem_d;
  logic [DetW-1:0]     dsr_q, dsr_d;
  logic [DetW:0]       shifted;
  logic [DetW:0]       diff;
  logic                ge;

  // The partial remainder stays below twice the divisor, so the top bit of
  // the difference is the borrow of the trial subtraction.
  assign shifted = {rem_q, quot_q[PosW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = !diff[DetW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[PosW-2:0], ge};
      rem_d  = ge ? diff[DetW-1:0] : shifted[DetW-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(PosW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

/* hw/rtl/haptic_detent_snap.sv */
// ----------------------------------------------------------------------------
// haptic_detent_snap
// Snaps encoder readings to detent targets for a position-mode motor.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_axis_tready_o is high only while the
// sequencer is idle. Track (cmd 0) runs the shared 32-step serial divider
// twice, once to round the origin-relative position to the nearest detent
// and once to reduce that detent count modulo the number of detents, then
// goes to the output state. Move (cmd 1) passes through a multiply state
// for a 16x16 multiply before the output state. Continuous (cmd 2) and
// the unused code go straight to the output state. The next item is taken
// once the sequencer is back in idle. The result sits in an output
// register, so the next item may be taken while it waits; a new result
// waits in the output state until that register frees up. Config writes
// are always taken and must only be made while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module haptic_detent_snap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hds_pkg::CfgIdW-1:0]    cfg_index_i,
  input  logic [hds_pkg::PosW-1:0]      cfg_data_i,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // position[31:0], detent_number[47:32], center_target[79:48]
  input  logic [hds_pkg::DataW-1:0]     s_axis_tdata_i,
  // cmd[1:0]
  input  logic [hds_pkg::CmdW-1:0]      s_axis_tuser_i,
  // Result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // target_counts[31:0], step_index[47:32], raw_position[79:48]
  output logic [hds_pkg::DataW-1:0]     m_axis_tdata_o,
  // send_target[0]
  output logic                          m_axis_tuser_o
);
  import hds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SNAP,
    S_MOD,
    S_MUL,
    S_OUT
  } state_e;

  // Config registers
  logic [PosW-1:0] origin_q;
  logic [DetW-1:0] steps_q;
  logic [DetW-1:0] counts_q;
  logic [DetW-1:0] eff_steps;
  logic [DetW-1:0] eff_counts;

  // Sequencer and item registers
  state_e          state_q, state_d;
  hds_cmd_e        cmd_q, cmd_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [DetW-1:0] det_q, det_d;
  logic [PosW-1:0] ctr_q, ctr_d;
  logic            neg_q, neg_d;
  logic [PosW-1:0] num_q, num_d;
  logic [PosW-1:0] res_target_q, res_target_d;
  logic [DetW-1:0] res_index_q, res_index_d;
  logic [PosW-1:0] last_q, last_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [PosW-1:0] out_target_q, out_target_d;
  logic            out_send_q, out_send_d;
  logic [DetW-1:0] out_index_q, out_index_d;
  logic [PosW-1:0] out_raw_q, out_raw_d;

  // Shared divider
  logic            div_start;
  logic [PosW-1:0] div_dividend;
  logic [DetW-1:0] div_divisor;
  hds_div_stat_t   div_stat;
  logic [PosW-1:0] div_quot;
  logic [DetW-1:0] div_rem;

  logic            in_xfer;
  hds_cmd_e        in_cmd;
  logic [PosW-1:0] in_pos;
  logic [PosW-1:0] rel;
  logic [PosW-1:0] mag;
  logic [PosW-1:0] num_w;
  logic [PosW-1:0] snap_prod;
  logic [PosW-1:0] snap_off;
  logic [PosW-1:0] mul_w;
  logic            out_free;

  // Treat fewer than two detents as two and zero counts as one.
  assign eff_steps  = (steps_q < DetW'(2)) ? DetW'(2) : steps_q;
  assign eff_counts = (counts_q == '0) ? DetW'(1) : counts_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cmd          = hds_cmd_e'(s_axis_tuser_i);
  assign in_pos          = s_axis_tdata_i[PosW-1:0];

  // Sign and magnitude of the origin-relative position, biased by half a
  // detent so that truncating division rounds halves away from zero.
  assign rel   = in_pos - origin_q;
  assign mag   = rel[PosW-1] ? (~rel + 1'b1) : rel;
  assign num_w = mag + {{(PosW-DetW+1){1'b0}}, eff_counts[DetW-1:1]};

  // Nearest multiple = biased numerator minus remainder.
  assign snap_prod = num_q - {{(PosW-DetW){1'b0}}, div_rem};
  assign snap_off  = neg_q ? (~snap_prod + 1'b1) : snap_prod;

  assign mul_w = {{(PosW-DetW){1'b0}}, det_q} * {{(PosW-DetW){1'b0}}, eff_counts};

  // First pass divides by counts per detent, second by the detent count.
  assign div_start    = (in_xfer && (in_cmd == CMD_TRACK)) ||
                        ((state_q == S_SNAP) && div_stat.done);
  assign div_dividend = (state_q == S_SNAP) ? div_quot : num_w;
  assign div_divisor  = (state_q == S_SNAP) ? eff_steps : eff_counts;

  hds_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    pos_d        = pos_q;
    det_d        = det_q;
    ctr_d        = ctr_q;
    neg_d        = neg_q;
    num_d        = num_q;
    res_target_d = res_target_q;
    res_index_d  = res_index_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_target_d = out_target_q;
    out_send_d   = out_send_q;
    out_index_d  = out_index_q;
    out_raw_d    = out_raw_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          // Capture the item and pick the path for its command.
          cmd_d = in_cmd;
          pos_d = in_pos;
          det_d = s_axis_tdata_i[PosW+DetW-1:PosW];
          ctr_d = s_axis_tdata_i[DataW-1:PosW+DetW];
          neg_d = rel[PosW-1];
          num_d = num_w;
          case (in_cmd)
            CMD_TRACK: state_d = S_SNAP;
            CMD_MOVE:  state_d = S_MUL;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_SNAP: begin
        if (div_stat.done) begin
          res_target_d = origin_q + snap_off;
          state_d      = S_MOD;
        end
      end
      S_MOD: begin
        if (div_stat.done) begin
          // Fold negative detent counts back into range.
          res_index_d = (neg_q && (div_rem != '0)) ? (eff_steps - div_rem) : div_rem;
          state_d     = S_OUT;
        end
      end
      S_MUL: begin
        res_target_d = origin_q + mul_w;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_target_d = '0;
          out_send_d   = 1'b0;
          out_index_d  = '0;
          out_raw_d    = '0;
          case (cmd_q)
            CMD_TRACK: begin
              out_target_d = res_target_q;
              out_send_d   = (res_target_q != last_q);
              out_index_d  = res_index_q;
            end
            CMD_MOVE: begin
              out_target_d = res_target_q;
              out_send_d   = 1'b1;
            end
            CMD_CONTINUOUS: begin
              out_target_d = ctr_q;
              out_send_d   = (ctr_q != last_q);
              out_raw_d    = pos_q;
            end
            default: ;
          endcase
          // Remember every target flagged for sending.
          if (out_send_d) begin
            last_d = out_target_d;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      origin_q    <= '0;
      steps_q     <= DetW'(2);
      counts_q    <= DetW'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (hds_reg_e'(cfg_index_i))
          REG_ORIGIN: origin_q <= cfg_data_i;
          REG_STEPS:  steps_q  <= cfg_data_i[DetW-1:0];
          REG_COUNTS: counts_q <= cfg_data_i[DetW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pos_q        <= pos_d;
    det_q        <= det_d;
    ctr_q        <= ctr_d;
    neg_q        <= neg_d;
    num_q        <= num_d;
    res_target_q <= res_target_d;
    res_index_q  <= res_index_d;
    out_target_q <= out_target_d;
    out_send_q   <= out_send_d;
    out_index_q  <= out_index_d;
    out_raw_q    <= out_raw_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_raw_q, out_index_q, out_target_q};
  assign m_axis_tuser_o  = out_send_q;

  // An accepted item always leaves the idle state.
  `ASSERT_PROP(a_busy_after_xfer, clk_i, rst_ni,
    in_xfer |=> !s_axis_tready_o, "input taken twice in a row")
  // The divider runs only for the two division passes.
  `ASSERT_PROP(a_div_in_seq, clk_i, rst_ni,
    div_stat.busy |-> (state_q == S_SNAP || state_q == S_MOD),
    "divider busy outside a division pass")
  `ASSERT_NEVER(a_div_done_stray, clk_i, rst_ni,
    div_stat.done && !(state_q == S_SNAP || state_q == S_MOD),
    "divider finished with no pass waiting")
  // A flagged target is the one kept for the next comparison.
  `ASSERT_PROP(a_last_tracks_send, clk_i, rst_ni,
    ($rose(m_axis_tvalid_o) && m_axis_tuser_o) |-> (last_q == m_axis_tdata_o[PosW-1:0]),
    "kept target differs from sent target")

endmodule
